// ----- design/uat_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uat_pkg
// Types and codes shared by the card key allowlist table.
// ----------------------------------------------------------------------------
package uat_pkg;

	localparam int KEY_W   = 64;
	localparam int TOTAL_W = 5;

	// request codes; the reserved code behaves as a check
	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_CHECK  = 2'd2;

	// result status codes
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_FULL    = 2'd1;
	localparam logic [1:0] STAT_DUP     = 2'd2;
	localparam logic [1:0] STAT_MISSING = 2'd3;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [KEY_W-1:0] card_key;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic               present;
		logic [TOTAL_W-1:0] entry_total;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_MOVE,
		ST_REPLY
	} uat_state_t;

endpackage

// ----- design/uat_key_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uat_key_ram
// Key storage: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module uat_key_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int DW    = 64
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- design/uid_allowlist_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uid_allowlist_table
// Unordered allowlist of 64-bit card keys with add, remove and check.
// ----------------------------------------------------------------------------
// Usage:
//   req (req_valid/req_stall) carries one request: a code and a card key.
//   rsp (rsp_valid/rsp_stall) returns one result per request: status, the
//   lookup hit flag and the entry count after the request.
//   Keys live in a single-port-read RAM; the lookup reads one slot per cycle
//   and stops at the first hit or at the last valid slot. A remove then
//   reads the last entry and writes it into the freed slot.
//   From acceptance, a request passes through ST_SCAN (skipped on an empty
//   table), ST_DECIDE, ST_MOVE (only for a remove that hits) and ST_REPLY
//   before rsp_valid rises; a scan that hits early ends sooner. One request
//   is in flight at a time, so a new request is taken only once the last
//   result has moved into the output register.
//   Reset empties the table at once (count to zero); slot contents are left
//   as they are and only slots below the count are ever read.
//   The result sits in an output register. While rsp_stall holds it, the
//   next request is still taken and processed; it waits at the end until
//   the output register frees up.
// ----------------------------------------------------------------------------
module uid_allowlist_table #(
	parameter int TABLE_SLOTS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  uat_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output uat_pkg::rsp_t rsp
);

	localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int CW = $clog2(TABLE_SLOTS + 1);
	localparam logic [CW-1:0] SLOTS_C = CW'(TABLE_SLOTS);

	uat_pkg::uat_state_t state_q, state_d;

	logic [CW-1:0]              fill_q;
	logic [CW-1:0]              issue_q;
	logic                       rd_vld_s1;
	logic [IW-1:0]              rd_idx_s1;
	logic [uat_pkg::KEY_W-1:0]  rd_data_s1;
	logic [uat_pkg::KEY_W-1:0]  key_q;
	logic [1:0]                 op_q;
	logic                       found_q;
	logic [IW-1:0]              slot_q;
	logic [1:0]                 status_q;
	logic                       rsp_valid_q;
	uat_pkg::rsp_t              rsp_q;

	logic                       req_acc;
	logic                       rsp_free;
	logic [CW-1:0]              fill_last;
	logic                       scan_rd;
	logic                       scan_hit;
	logic                       scan_end;
	logic                       mem_we;
	logic [IW-1:0]              mem_waddr;
	logic [uat_pkg::KEY_W-1:0]  mem_wdata;
	logic                       mem_re;
	logic [IW-1:0]              mem_raddr;
	logic [1:0]                 status_d;
	logic                       fill_inc;
	logic                       fill_dec;

	assign req_stall = (state_q != uat_pkg::ST_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign fill_last = fill_q - CW'(1);
	assign scan_rd   = (state_q == uat_pkg::ST_SCAN) && (issue_q < fill_q);
	assign scan_hit  = rd_vld_s1 && (rd_data_s1 == key_q);
	assign scan_end  = (state_q == uat_pkg::ST_SCAN) && rd_vld_s1 &&
	                   (scan_hit || (CW'(rd_idx_s1) == fill_last));

	uat_key_ram #(
		.DEPTH (TABLE_SLOTS),
		.AW    (IW),
		.DW    (uat_pkg::KEY_W)
	) u_key_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rd_data_s1)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			uat_pkg::ST_IDLE: begin
				if (req_acc) begin
					state_d = (fill_q == '0) ? uat_pkg::ST_DECIDE : uat_pkg::ST_SCAN;
				end
			end
			uat_pkg::ST_SCAN: begin
				if (scan_end) begin
					state_d = uat_pkg::ST_DECIDE;
				end
			end
			uat_pkg::ST_DECIDE: begin
				state_d = (op_q == uat_pkg::OP_REMOVE && found_q) ?
				          uat_pkg::ST_MOVE : uat_pkg::ST_REPLY;
			end
			uat_pkg::ST_MOVE: begin
				state_d = uat_pkg::ST_REPLY;
			end
			uat_pkg::ST_REPLY: begin
				if (rsp_free) begin
					state_d = uat_pkg::ST_IDLE;
				end
			end
			default: state_d = uat_pkg::ST_IDLE;
		endcase
	end

	// memory controls and decision
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = slot_q;
		mem_wdata = rd_data_s1;
		mem_re    = 1'b0;
		mem_raddr = issue_q[IW-1:0];
		status_d  = status_q;
		fill_inc  = 1'b0;
		fill_dec  = 1'b0;
		unique case (state_q)
			uat_pkg::ST_SCAN: begin
				mem_re = scan_rd;
			end
			uat_pkg::ST_DECIDE: begin
				case (op_q)
					uat_pkg::OP_ADD: begin
						if (fill_q == SLOTS_C) begin
							status_d = uat_pkg::STAT_FULL;
						end else if (found_q) begin
							status_d = uat_pkg::STAT_DUP;
						end else begin
							status_d  = uat_pkg::STAT_OK;
							mem_we    = 1'b1;
							mem_waddr = fill_q[IW-1:0];
							mem_wdata = key_q;
							fill_inc  = 1'b1;
						end
					end
					uat_pkg::OP_REMOVE: begin
						status_d  = found_q ? uat_pkg::STAT_OK : uat_pkg::STAT_MISSING;
						mem_re    = found_q;
						mem_raddr = fill_last[IW-1:0];
					end
					default: begin
						status_d = found_q ? uat_pkg::STAT_OK : uat_pkg::STAT_MISSING;
					end
				endcase
			end
			uat_pkg::ST_MOVE: begin
				// last entry fills the hole
				mem_we   = 1'b1;
				fill_dec = 1'b1;
			end
			uat_pkg::ST_IDLE, uat_pkg::ST_REPLY: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= uat_pkg::ST_IDLE;
			fill_q      <= '0;
			issue_q     <= '0;
			rd_vld_s1   <= 1'b0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= scan_rd;
			if (fill_inc) begin
				fill_q <= fill_q + CW'(1);
			end else if (fill_dec) begin
				fill_q <= fill_last;
			end
			if (req_acc) begin
				issue_q <= '0;
				found_q <= 1'b0;
			end else begin
				if (scan_rd) begin
					issue_q <= issue_q + CW'(1);
				end
				if (state_q == uat_pkg::ST_SCAN && scan_hit) begin
					found_q <= 1'b1;
				end
			end
			if (state_q == uat_pkg::ST_REPLY && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			key_q <= req.card_key;
			op_q  <= req.req_type;
		end
		if (scan_rd) begin
			rd_idx_s1 <= issue_q[IW-1:0];
		end
		if (state_q == uat_pkg::ST_SCAN && scan_hit) begin
			slot_q <= rd_idx_s1;
		end
		if (state_q == uat_pkg::ST_DECIDE) begin
			status_q <= status_d;
		end
		if (state_q == uat_pkg::ST_REPLY && rsp_free) begin
			rsp_q.status      <= status_q;
			rsp_q.present     <= found_q;
			rsp_q.entry_total <= uat_pkg::TOTAL_W'(fill_q);
		end
	end

	// ------------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------------
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= SLOTS_C)
		else $error("entry count beyond table size");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == uat_pkg::ST_SCAN) |-> (issue_q <= fill_q))
		else $error("scan read past last valid slot");

	a_write_bound: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (CW'(mem_waddr) <= fill_q && CW'(mem_waddr) < SLOTS_C))
		else $error("key write outside valid range");

	a_add_count: assert property (@(posedge clk) disable iff (!arst_n)
		fill_inc |=> (fill_q == $past(fill_q) + CW'(1)))
		else $error("successful add did not bump the count");

	a_move_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == uat_pkg::ST_MOVE) |-> (found_q && fill_q != '0 &&
		 op_q == uat_pkg::OP_REMOVE))
		else $error("entry move without a matching remove");

endmodule
